### sv/nirp_pkg.sv
// Package for the NEC IR pulse decoder: register indexes, reset values,
// decoder stage encoding and stream word widths.
// No dependencies.
package nirp_pkg;

  localparam int unsigned CntW     = 16;
  localparam int unsigned TolW     = 8;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned BitPosW  = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 40;

  localparam logic [TolW-1:0]  TolReset     = 8'd64;
  localparam logic [CntW-1:0]  LeaderReset  = 16'd1125;
  localparam logic [CntW-1:0]  HeaderReset  = 16'd562;
  localparam logic [CntW-1:0]  RepeatReset  = 16'd281;
  localparam logic [CntW-1:0]  OneReset     = 16'd281;
  localparam logic [CntW-1:0]  ZeroReset    = 16'd140;
  localparam logic [ByteW-1:0] TimeoutReset = 8'd200;

  localparam logic [ByteW-1:0] OvfMax   = 8'hFF;
  localparam logic [ByteW-1:0] CheckXor = 8'hFF;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TOLERANCE = 3'd0,
    REG_LEADER    = 3'd1,
    REG_HEADER    = 3'd2,
    REG_REPEAT    = 3'd3,
    REG_ONE       = 3'd4,
    REG_ZERO      = 3'd5,
    REG_TIMEOUT   = 3'd6
  } cfg_reg_e;

  typedef enum logic [5:0] {
    ST_LEADER = 6'b000001,
    ST_SPACE  = 6'b000010,
    ST_ADDR1  = 6'b000100,
    ST_ADDR2  = 6'b001000,
    ST_CMD1   = 6'b010000,
    ST_CMD2   = 6'b100000
  } stage_e;

  typedef enum logic {
    CMD_EDGE     = 1'b0,
    CMD_OVERFLOW = 1'b1
  } in_cmd_e;

  typedef struct packed {
    logic             frame_done;
    logic [ByteW-1:0] addr_lo;
    logic [ByteW-1:0] addr_hi;
    logic [ByteW-1:0] key_code;
    logic [ByteW-1:0] repeat_total;
    logic             wanted_edge;
    logic             timer_clear;
  } result_t;

  function automatic logic in_window(logic [CntW-1:0] cnt, logic [CntW-1:0] nominal,
                                     logic [TolW-1:0] tol);
    logic [CntW-1:0] diff;
    diff = (cnt >= nominal) ? (cnt - nominal) : (nominal - cnt);
    return diff < {{(CntW-TolW){1'b0}}, tol};
  endfunction

endpackage

### sv/nec_ir_pulse_decoder.sv
// NEC infrared frame decoder driven by edge timings and timer overflow ticks.
// Depends on nirp_pkg.
//
// Takes one word per clock cycle and returns exactly one result word per input
// word. The decoder state is updated in the cycle a word is accepted and the
// result sits in a single output register, so a word can enter every cycle
// while the downstream side takes results. Input is stalled only while the
// output register is full and not being taken.
module nec_ir_pulse_decoder
  import nirp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [7:0] counter_low
  input  logic                s_axis_tuser,   // [0] command
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [7:0] addr_lo, [15:8] addr_hi, [23:16] key_code,
  // [31:24] repeat_total, [32] wanted_edge, [33] timer_clear, [39:34] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tuser    // [0] frame_done
);

  logic [TolW-1:0]  tol_q;
  logic [CntW-1:0]  leader_q, header_q, repeat_q, one_q, zero_q;
  logic [ByteW-1:0] timeout_q;

  stage_e              stage_q, stage_d;
  logic                phase_q, phase_d;
  logic [BitPosW-1:0]  bitpos_q, bitpos_d;
  logic [ByteW-1:0]    addr1_q, addr1_d, addr2_q, addr2_d;
  logic [ByteW-1:0]    cmdp_q, cmdp_d, cmdi_q, cmdi_d;
  logic [ByteW-1:0]    ovf_q, ovf_d, rep_q, rep_d;
  logic                seen_q, seen_d;

  logic                out_valid_q;
  result_t             res_q, res_d;

  logic                in_fire;
  logic [CntW-1:0]     cnt;
  logic [ByteW-1:0]    ovf_inc;
  logic                bit_val;
  logic [ByteW-1:0]    bit_mask;
  logic [BitPosW-1:0]  bitpos_inc;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.frame_done;
  assign m_axis_tdata  = {6'd0, res_q.timer_clear, res_q.wanted_edge, res_q.repeat_total,
                          res_q.key_code, res_q.addr_hi, res_q.addr_lo};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q     <= TolReset;
      leader_q  <= LeaderReset;
      header_q  <= HeaderReset;
      repeat_q  <= RepeatReset;
      one_q     <= OneReset;
      zero_q    <= ZeroReset;
      timeout_q <= TimeoutReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_TOLERANCE: tol_q     <= cfg_data_i[TolW-1:0];
        REG_LEADER:    leader_q  <= cfg_data_i;
        REG_HEADER:    header_q  <= cfg_data_i;
        REG_REPEAT:    repeat_q  <= cfg_data_i;
        REG_ONE:       one_q     <= cfg_data_i;
        REG_ZERO:      zero_q    <= cfg_data_i;
        REG_TIMEOUT:   timeout_q <= cfg_data_i[ByteW-1:0];
        default: ;
      endcase
    end
  end

  assign cnt        = {ovf_q, s_axis_tdata};
  assign ovf_inc    = (ovf_q == OvfMax) ? ovf_q : ovf_q + 8'd1;
  assign bit_val    = in_window(cnt, one_q, tol_q);
  assign bit_mask   = {{(ByteW-1){1'b0}}, bit_val} << bitpos_q;
  assign bitpos_inc = bitpos_q + 3'd1;

  always_comb begin
    stage_d  = stage_q;
    phase_d  = phase_q;
    bitpos_d = bitpos_q;
    addr1_d  = addr1_q;
    addr2_d  = addr2_q;
    cmdp_d   = cmdp_q;
    cmdi_d   = cmdi_q;
    ovf_d    = ovf_q;
    rep_d    = rep_q;
    seen_d   = seen_q;
    res_d    = '0;

    if (s_axis_tuser == CMD_OVERFLOW) begin
      ovf_d = ovf_inc;
      if (ovf_inc > timeout_q) begin
        stage_d = ST_LEADER;
        seen_d  = 1'b0;
      end
    end else begin
      ovf_d             = '0;
      res_d.timer_clear = 1'b1;
      case (stage_q)
        ST_LEADER: begin
          phase_d = !phase_q;
          if (phase_q && in_window(cnt, leader_q, tol_q)) begin
            stage_d = ST_SPACE;
          end
        end
        ST_SPACE: begin
          if (in_window(cnt, header_q, tol_q)) begin
            stage_d  = ST_ADDR1;
            bitpos_d = '0;
            addr1_d  = '0;
            addr2_d  = '0;
            cmdp_d   = '0;
            cmdi_d   = '0;
          end else begin
            stage_d = ST_LEADER;
            if (in_window(cnt, repeat_q, tol_q) && seen_q) begin
              rep_d = rep_q + 8'd1;
            end
          end
        end
        ST_ADDR1, ST_ADDR2, ST_CMD1, ST_CMD2: begin
          if (!bit_val && !in_window(cnt, zero_q, tol_q)) begin
            stage_d = ST_LEADER;
          end else begin
            bitpos_d = bitpos_inc;
            case (stage_q)
              ST_ADDR1: addr1_d = addr1_q | bit_mask;
              ST_ADDR2: addr2_d = addr2_q | bit_mask;
              ST_CMD1:  cmdp_d  = cmdp_q | bit_mask;
              default:  cmdi_d  = cmdi_q | bit_mask;
            endcase
            if (bitpos_inc == '0) begin
              case (stage_q)
                ST_ADDR1: stage_d = ST_ADDR2;
                ST_ADDR2: stage_d = ST_CMD1;
                ST_CMD1:  stage_d = ST_CMD2;
                default: begin
                  stage_d = ST_LEADER;
                  if ((cmdp_q ^ cmdi_d) == CheckXor) begin
                    res_d.frame_done = 1'b1;
                    res_d.addr_lo    = addr1_q;
                    res_d.addr_hi    = addr2_q;
                    res_d.key_code   = cmdp_q;
                    rep_d            = '0;
                    seen_d           = 1'b1;
                  end
                end
              endcase
            end
          end
        end
        default: stage_d = ST_LEADER;
      endcase
    end

    res_d.repeat_total = rep_d;
    res_d.wanted_edge  = phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q     <= ST_LEADER;
      phase_q     <= 1'b0;
      bitpos_q    <= '0;
      addr1_q     <= '0;
      addr2_q     <= '0;
      cmdp_q      <= '0;
      cmdi_q      <= '0;
      ovf_q       <= '0;
      rep_q       <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        stage_q  <= stage_d;
        phase_q  <= phase_d;
        bitpos_q <= bitpos_d;
        addr1_q  <= addr1_d;
        addr2_q  <= addr2_d;
        cmdp_q   <= cmdp_d;
        cmdi_q   <= cmdi_d;
        ovf_q    <= ovf_d;
        rep_q    <= rep_d;
        seen_q   <= seen_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  a_done_on_edge : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[33])
    else $error("frame reported on an overflow tick");

  a_edge_clears_ovf : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && s_axis_tuser == CMD_EDGE |=> ovf_q == '0)
    else $error("edge did not clear overflow count");

  a_frame_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && res_d.frame_done |=> seen_q && rep_q == '0 && stage_q == ST_LEADER)
    else $error("good frame did not reset repeat tracking");

  a_result_tracks_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> m_axis_tvalid && m_axis_tdata[31:24] == rep_q
                && m_axis_tdata[32] == phase_q)
    else $error("result word disagrees with decoder state");

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for nec_ir_pulse_decoder: directed pulse table, then random NEC frames,
// repeat codes, noise and overflow storms under several timing setups. Depends on nirp_pkg.
module tb_top;
  import nirp_pkg::*;

  localparam int NumDir     = 24;
  localparam int NumPhases  = 9;
  localparam int CycleLimit = 1000000;

  typedef struct packed {
    in_cmd_e    cmd;
    logic [7:0] low;
  } ir_word_t;

  typedef struct packed {
    in_cmd_e    cmd;
    logic [7:0] low;
    logic       typed;
    logic       edge_w;
    logic       clr_w;
  } dir_row_t;

  localparam dir_row_t DirRows [NumDir] = '{
    '{CMD_OVERFLOW, 8'h00, 1'b1, 1'b0, 1'b0},
    '{CMD_EDGE,     8'hFF, 1'b1, 1'b1, 1'b1},
    '{CMD_EDGE,     8'h00, 1'b1, 1'b0, 1'b1},
    '{CMD_EDGE,     8'hA5, 1'b1, 1'b1, 1'b1},
    '{CMD_OVERFLOW, 8'h5A, 1'b1, 1'b1, 1'b0},
    '{CMD_OVERFLOW, 8'hFF, 1'b1, 1'b1, 1'b0},
    '{CMD_OVERFLOW, 8'h00, 1'b1, 1'b1, 1'b0},
    '{CMD_OVERFLOW, 8'h81, 1'b1, 1'b1, 1'b0},
    '{CMD_EDGE,     8'd101, 1'b1, 1'b0, 1'b1},
    '{CMD_EDGE,     8'hFF, 1'b1, 1'b0, 1'b1},
    '{CMD_EDGE,     8'h00, 1'b1, 1'b1, 1'b1},
    '{CMD_OVERFLOW, 8'h3C, 1'b1, 1'b1, 1'b0},
    '{CMD_OVERFLOW, 8'hC3, 1'b1, 1'b1, 1'b0},
    '{CMD_OVERFLOW, 8'h01, 1'b1, 1'b1, 1'b0},
    '{CMD_OVERFLOW, 8'h80, 1'b1, 1'b1, 1'b0},
    '{CMD_EDGE,     8'd164, 1'b0, 1'b0, 1'b0},
    '{CMD_OVERFLOW, 8'h55, 1'b0, 1'b0, 1'b0},
    '{CMD_OVERFLOW, 8'hAA, 1'b0, 1'b0, 1'b0},
    '{CMD_EDGE,     8'd50, 1'b0, 1'b0, 1'b0},
    '{CMD_OVERFLOW, 8'h7E, 1'b0, 1'b0, 1'b0},
    '{CMD_EDGE,     8'd25, 1'b0, 1'b0, 1'b0},
    '{CMD_EDGE,     8'd140, 1'b0, 1'b0, 1'b0},
    '{CMD_EDGE,     8'h00, 1'b0, 1'b0, 1'b0},
    '{CMD_EDGE,     8'h00, 1'b1, 1'b1, 1'b1}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;   // [7:0] counter_low
  logic                s_axis_tuser = 1'b0; // [0] command
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [7:0] addr_lo, [15:8] addr_hi, [23:16] key_code,
  // [31:24] repeat_total, [32] wanted_edge, [33] timer_clear
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;        // [0] frame_done

  // decoder timing setup as the bench believes it
  logic [TolW-1:0]  cfg_tol     = TolReset;
  logic [CntW-1:0]  cfg_leader  = LeaderReset;
  logic [CntW-1:0]  cfg_header  = HeaderReset;
  logic [CntW-1:0]  cfg_repeat  = RepeatReset;
  logic [CntW-1:0]  cfg_one     = OneReset;
  logic [CntW-1:0]  cfg_zero    = ZeroReset;
  logic [ByteW-1:0] cfg_timeout = TimeoutReset;

  // decoder state as the bench believes it
  stage_e           dec_stage  = ST_LEADER;
  logic             edge_ph    = 1'b0;
  logic [BitPosW-1:0] bit_pos  = '0;
  logic [ByteW-1:0] addr_lo_r  = '0;
  logic [ByteW-1:0] addr_hi_r  = '0;
  logic [ByteW-1:0] key_r      = '0;
  logic [ByteW-1:0] key_inv_r  = '0;
  logic [ByteW-1:0] ovf_cnt    = '0;
  logic [ByteW-1:0] rep_cnt    = '0;
  logic             frame_seen = 1'b0;

  result_t  pending_results [$];
  ir_word_t pulse_q [$];
  int       err_cnt = 0;
  int       results_seen = 0;
  bit       src_calm = 1'b0;

  nec_ir_pulse_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic in_tol(logic [CntW-1:0] span, logic [CntW-1:0] nominal);
    int delta;
    delta = int'(span) - int'(nominal);
    if (delta < 0) delta = -delta;
    return delta < int'(cfg_tol);
  endfunction

  function automatic result_t decode_pulse(in_cmd_e cmd, logic [7:0] low);
    result_t         r;
    logic [CntW-1:0] span;
    logic            bit_val;
    logic            hit;
    r = '0;
    if (cmd == CMD_OVERFLOW) begin
      if (ovf_cnt != OvfMax) ovf_cnt = ovf_cnt + 8'd1;
      if (ovf_cnt > cfg_timeout) begin
        dec_stage  = ST_LEADER;
        frame_seen = 1'b0;
      end
    end else begin
      span = {ovf_cnt, low};
      ovf_cnt = '0;
      r.timer_clear = 1'b1;
      if (dec_stage == ST_LEADER) begin
        if (!edge_ph) begin
          edge_ph = 1'b1;
        end else begin
          edge_ph = 1'b0;
          if (in_tol(span, cfg_leader)) dec_stage = ST_SPACE;
        end
      end else if (dec_stage == ST_SPACE) begin
        if (in_tol(span, cfg_header)) begin
          dec_stage = ST_ADDR1;
          bit_pos   = '0;
          addr_lo_r = '0;
          addr_hi_r = '0;
          key_r     = '0;
          key_inv_r = '0;
        end else begin
          if (in_tol(span, cfg_repeat) && frame_seen) rep_cnt = rep_cnt + 8'd1;
          dec_stage = ST_LEADER;
        end
      end else begin
        hit = 1'b1;
        bit_val = 1'b0;
        if (in_tol(span, cfg_one)) begin
          bit_val = 1'b1;
        end else if (!in_tol(span, cfg_zero)) begin
          hit = 1'b0;
          dec_stage = ST_LEADER;
        end
        if (hit) begin
          case (dec_stage)
            ST_ADDR1: addr_lo_r[bit_pos] = addr_lo_r[bit_pos] | bit_val;
            ST_ADDR2: addr_hi_r[bit_pos] = addr_hi_r[bit_pos] | bit_val;
            ST_CMD1:  key_r[bit_pos]     = key_r[bit_pos] | bit_val;
            default:  key_inv_r[bit_pos] = key_inv_r[bit_pos] | bit_val;
          endcase
          bit_pos = bit_pos + 3'd1;
          if (bit_pos == '0) begin
            case (dec_stage)
              ST_ADDR1: dec_stage = ST_ADDR2;
              ST_ADDR2: dec_stage = ST_CMD1;
              ST_CMD1:  dec_stage = ST_CMD2;
              default: begin
                if ((key_r ^ key_inv_r) == CheckXor) begin
                  r.frame_done = 1'b1;
                  r.addr_lo    = addr_lo_r;
                  r.addr_hi    = addr_hi_r;
                  r.key_code   = key_r;
                  rep_cnt      = '0;
                  frame_seen   = 1'b1;
                end
                dec_stage = ST_LEADER;
              end
            endcase
          end
        end
      end
    end
    r.repeat_total = rep_cnt;
    r.wanted_edge  = edge_ph;
    return r;
  endfunction

  function automatic int idle_len(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic ir_word_t word(in_cmd_e cmd, logic [7:0] low);
    ir_word_t w;
    w.cmd = cmd;
    w.low = low;
    return w;
  endfunction

  function automatic int pick_span(int nominal, int miss_odds);
    int off;
    int t;
    if ($urandom_range(1, miss_odds) == 1) begin
      if ($urandom_range(0, 1) == 1) return $urandom_range(0, 1023);
      off = int'(cfg_tol);
    end else if (cfg_tol == '0) begin
      off = 0;
    end else begin
      off = $urandom_range(0, int'(cfg_tol) - 1);
    end
    t = ($urandom_range(0, 1) == 1) ? nominal + off : nominal - off;
    if (t < 0) t = nominal + off;
    if (t > 65535) t = nominal - off;
    return t;
  endfunction

  function automatic void push_span(int t);
    int n;
    n = t >> 8;
    repeat (n) pulse_q.push_back(word(CMD_OVERFLOW, 8'($urandom_range(0, 255))));
    pulse_q.push_back(word(CMD_EDGE, t[7:0]));
  endfunction

  function automatic void push_repeat_code();
    pulse_q.push_back(word(CMD_EDGE, 8'($urandom_range(0, 255))));
    push_span(pick_span(int'(cfg_leader), 12));
    push_span(pick_span(int'(cfg_repeat), 12));
  endfunction

  function automatic void build_sequence();
    int          pick;
    int          n;
    logic [31:0] payload;
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      n = $urandom_range(150, 300);
      repeat (n) pulse_q.push_back(word(CMD_OVERFLOW, 8'($urandom_range(0, 255))));
      pulse_q.push_back(word(CMD_EDGE, 8'($urandom_range(0, 255))));
    end else if (pick < 22) begin
      n = $urandom_range(1, 8);
      repeat (n) pulse_q.push_back(word(in_cmd_e'($urandom_range(0, 1)),
                                        8'($urandom_range(0, 255))));
    end else begin
      if (edge_ph) pulse_q.push_back(word(CMD_EDGE, 8'($urandom_range(0, 255))));
      if ($urandom_range(0, 3) == 0) begin
        push_repeat_code();
      end else begin
        pulse_q.push_back(word(CMD_EDGE, 8'($urandom_range(0, 255))));
        push_span(pick_span(int'(cfg_leader), 12));
        push_span(pick_span(int'(cfg_header), 12));
        payload[23:0]  = 24'($urandom);
        payload[31:24] = ~payload[23:16];
        if ($urandom_range(0, 5) == 0) payload[31:24] = 8'($urandom_range(0, 255));
        for (int i = 0; i < 32; i++) begin
          push_span(pick_span(payload[i] ? int'(cfg_one) : int'(cfg_zero), 300));
        end
        n = $urandom_range(0, 3);
        repeat (n) push_repeat_code();
      end
    end
  endfunction

  task automatic write_reg(cfg_reg_e idx, int val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[15:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_TOLERANCE: cfg_tol     = val[7:0];
      REG_LEADER:    cfg_leader  = val[15:0];
      REG_HEADER:    cfg_header  = val[15:0];
      REG_REPEAT:    cfg_repeat  = val[15:0];
      REG_ONE:       cfg_one     = val[15:0];
      REG_ZERO:      cfg_zero    = val[15:0];
      default:       cfg_timeout = val[7:0];
    endcase
  endtask

  // upper byte of the 8-bit registers carries junk
  task automatic apply_setup(int tol, int leader, int header, int rpt, int one, int zero,
                             int tmo);
    write_reg(REG_TOLERANCE, ($urandom_range(0, 255) << 8) | tol);
    write_reg(REG_LEADER, leader);
    write_reg(REG_HEADER, header);
    write_reg(REG_REPEAT, rpt);
    write_reg(REG_ONE, one);
    write_reg(REG_ZERO, zero);
    write_reg(REG_TIMEOUT, ($urandom_range(0, 255) << 8) | tmo);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic setup_phase(int ph);
    case (ph)
      1: apply_setup(255, 65535, 0, 65535, 600, 0, 255);
      2: apply_setup(0, $urandom_range(0, 3000), $urandom_range(0, 2000),
                     $urandom_range(0, 1500), 65535, 65535, 0);
      3: apply_setup(1, $urandom_range(0, 3000), $urandom_range(0, 2000),
                     $urandom_range(0, 1500), $urandom_range(0, 700),
                     $urandom_range(0, 700), 255);
      NumPhases: apply_setup(int'(TolReset), int'(LeaderReset), int'(HeaderReset),
                             int'(RepeatReset), int'(OneReset), int'(ZeroReset),
                             int'(TimeoutReset));
      default: apply_setup($urandom_range(2, 120), $urandom_range(0, 3000),
                           $urandom_range(0, 2000), $urandom_range(0, 1500),
                           $urandom_range(0, 700), $urandom_range(0, 700),
                           $urandom_range(8, 255));
    endcase
  endtask

  task automatic send_word(ir_word_t w);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w.low;
    s_axis_tuser  <= w.cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic source_idle();
    int g;
    if ($urandom_range(0, 99) == 0) src_calm = !src_calm;
    g = idle_len(src_calm);
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cmp_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  initial begin : source_side
    result_t  want;
    result_t  guess;
    ir_word_t w;
    int       quota;
    int       sent;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDir; i++) begin
      if (i > 0) source_idle();
      send_word(word(DirRows[i].cmd, DirRows[i].low));
      guess = decode_pulse(DirRows[i].cmd, DirRows[i].low);
      if (DirRows[i].typed) begin
        want = '0;
        want.wanted_edge = DirRows[i].edge_w;
        want.timer_clear = DirRows[i].clr_w;
        pending_results.push_back(want);
      end else begin
        pending_results.push_back(guess);
      end
    end
    s_axis_tvalid <= 1'b0;

    for (int ph = 1; ph <= NumPhases; ph++) begin
      drain_results();
      setup_phase(ph);
      quota = (ph == 1) ? 400 : (ph == 2) ? 100 : 190;
      sent = 0;
      while (sent < quota) begin
        if (pulse_q.size() == 0) build_sequence();
        w = pulse_q.pop_front();
        if (sent > 0) source_idle();
        send_word(w);
        pending_results.push_back(decode_pulse(w.cmd, w.low));
        sent++;
      end
      pulse_q.delete();
      s_axis_tvalid <= 1'b0;
    end

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : sink_side
    int hold;
    bit calm;
    bit held_once;
    hold = 0;
    calm = 1'b0;
    held_once = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 149) == 0) calm = !calm;
      // hold off long enough to back up the input side
      if (!held_once && results_seen >= 300) begin
        held_once = 1'b1;
        hold = 64;
      end
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        hold--;
      end else begin
        m_axis_tready <= 1'b1;
        hold = idle_len(calm);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen = results_seen + 1;
      if (pending_results.size() == 0) begin
        $error("result word with nothing pending");
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        cmp_field("frame_done", 32'(want.frame_done), 32'(m_axis_tuser));
        cmp_field("addr_lo", 32'(want.addr_lo), 32'(m_axis_tdata[7:0]));
        cmp_field("addr_hi", 32'(want.addr_hi), 32'(m_axis_tdata[15:8]));
        cmp_field("key_code", 32'(want.key_code), 32'(m_axis_tdata[23:16]));
        cmp_field("repeat_total", 32'(want.repeat_total), 32'(m_axis_tdata[31:24]));
        cmp_field("wanted_edge", 32'(want.wanted_edge), 32'(m_axis_tdata[32]));
        cmp_field("timer_clear", 32'(want.timer_clear), 32'(m_axis_tdata[33]));
      end
    end
  end

  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk_i);
    $display("tb: failure");
    $finish;
  end

endmodule
